/* hdl/idtp_pkg.sv */
// Shared types, character codes, field positions and helpers for the date-time text parser.
package idtp_pkg;

    typedef enum logic [2:0] {
        PH_BODY      = 3'd0,
        PH_AFTER_SEC = 3'd1,
        PH_FRAC      = 3'd2,
        PH_AFTER_Z   = 3'd3,
        PH_OFFSET    = 3'd4
    } phase_t;

    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 88;
    localparam int OUT_USER_W  = 4;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_Z     = 8'h5A;

    localparam logic [5:0] POS_YEAR_END   = 6'd4;
    localparam logic [5:0] POS_DASH1      = 6'd4;
    localparam logic [5:0] POS_DASH2      = 6'd7;
    localparam logic [5:0] POS_DATE_LAST  = 6'd9;
    localparam logic [5:0] POS_T          = 6'd10;
    localparam logic [5:0] POS_COLON1     = 6'd13;
    localparam logic [5:0] POS_COLON2     = 6'd16;
    localparam logic [5:0] POS_SEC_LAST   = 6'd18;
    localparam logic [5:0] POS_MAX        = 6'd63;
    localparam logic [5:0] POS_Y0         = 6'd0;
    localparam logic [5:0] POS_Y1         = 6'd1;
    localparam logic [5:0] POS_Y2         = 6'd2;
    localparam logic [5:0] POS_Y3         = 6'd3;

    localparam logic [2:0] OFS_IDX_FIRST    = 3'd1;
    localparam logic [2:0] OFS_IDX_HOUR_END = 3'd2;
    localparam logic [2:0] OFS_IDX_COLON    = 3'd3;
    localparam logic [2:0] OFS_IDX_LAST     = 3'd5;
    localparam logic [2:0] OFS_IDX_DONE     = 3'd6;

    localparam logic [1:0] OFS_NONE  = 2'd0;
    localparam logic [1:0] OFS_PLUS  = 2'd1;
    localparam logic [1:0] OFS_MINUS = 2'd2;

    localparam logic [3:0]  MAX_FRACTION_DIGITS = 4'd9;
    localparam logic [13:0] YEAR_MAX     = 14'd9999;
    localparam logic [6:0]  MONTH_MAX    = 7'd12;
    localparam logic [6:0]  HOUR_MAX     = 7'd23;
    localparam logic [6:0]  MINUTE_MAX   = 7'd59;
    localparam logic [6:0]  SECOND_MAX   = 7'd60;
    localparam logic [3:0]  MONTH_FEB    = 4'd2;

    function automatic logic [29:0] mul10_add(input logic [29:0] acc, input logic [3:0] dig);
        logic [29:0] res;
        res = (acc << 3) + (acc << 1) + {26'd0, dig};
        return res;
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] lim;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: lim = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   lim = 5'd30;
            MONTH_FEB:                                 lim = leap ? 5'd29 : 5'd28;
            default:                                   lim = 5'd0;
        endcase
        return lim;
    endfunction

endpackage

/* hdl/iso_datetime_text_parser.sv */
// Top level of the date-time text parser: character stream in, one parsed result per string out.
//
// Channel  | Dir | Beat content
// s_axis   | in  | tdata[7:0] character, tlast final character of the string
// m_axis   | out | tdata parsed fields, tuser valid/time-present/offset kind
//
// Each character is captured in an input register, then the field accumulators are updated and,
// on the final character, the whole check is done and the result register is loaded. One
// character per cycle is sustained unless a stall on m_axis holds a final character.
// Reset clears all parser state; after each final character the state returns to reset values.
// A stall on m_axis holds only a beat whose character is the final one of a string.
module iso_datetime_text_parser
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [7:0] ch
    input  logic [idtp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [13:0] year, [17:14] month, [22:18] day, [27:23] hour, [33:28] minute,
    // [39:34] second, [69:40] fraction_value, [73:70] fraction_digits,
    // [84:74] offset_minutes, [87:85] zero
    output logic [idtp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // [0] valid_res, [1] time_present, [3:2] offset_kind
    output logic [idtp_pkg::OUT_USER_W-1:0]    m_axis_tuser
);
    import idtp_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  ch_reg;
    logic        last_reg;

    logic        out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_USER_W-1:0] out_user_reg;

    logic [5:0]  pos_reg;
    phase_t      phase_reg;
    logic        err_reg;
    logic [13:0] year_reg;
    logic [6:0]  month_reg;
    logic [6:0]  day_reg;
    logic [6:0]  hour_reg;
    logic [6:0]  minute_reg;
    logic [6:0]  second_reg;
    logic [29:0] frac_reg;
    logic [3:0]  frac_cnt_reg;
    logic [1:0]  off_sign_reg;
    logic [6:0]  off_hour_reg;
    logic [6:0]  off_min_reg;
    logic [2:0]  off_idx_reg;
    logic [1:0]  ypair_reg;
    logic        yzero_reg;
    logic [1:0]  yhi_mod4_reg;
    logic [1:0]  ylo_mod4_reg;
    logic        ylo_zero_reg;

    logic [5:0]  pos_next;
    phase_t      phase_next;
    logic        err_next;
    logic [13:0] year_next;
    logic [6:0]  month_next;
    logic [6:0]  day_next;
    logic [6:0]  hour_next;
    logic [6:0]  minute_next;
    logic [6:0]  second_next;
    logic [29:0] frac_next;
    logic [3:0]  frac_cnt_next;
    logic [1:0]  off_sign_next;
    logic [6:0]  off_hour_next;
    logic [6:0]  off_min_next;
    logic [2:0]  off_idx_next;
    logic [1:0]  ypair_next;
    logic        yzero_next;
    logic [1:0]  yhi_mod4_next;
    logic [1:0]  ylo_mod4_next;
    logic        ylo_zero_next;

    logic        out_free;
    logic        proc_go;
    logic        is_dig;
    logic [3:0]  dig;
    logic        ok;
    logic        time_seen;
    logic        leap;
    logic [4:0]  day_lim;
    logic [12:0] off_total;
    logic [OUT_DATA_W-1:0] res_data;
    logic [OUT_USER_W-1:0] res_user;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign proc_go       = in_valid_reg && (!last_reg || out_free);
    assign s_axis_tready = !in_valid_reg || proc_go;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    assign is_dig = (ch_reg >= CH_0) && (ch_reg <= CH_9);
    assign dig    = 4'(ch_reg - CH_0);

    always_comb
    begin
        pos_next      = (pos_reg < POS_MAX) ? pos_reg + 6'd1 : pos_reg;
        phase_next    = phase_reg;
        err_next      = err_reg;
        year_next     = year_reg;
        month_next    = month_reg;
        day_next      = day_reg;
        hour_next     = hour_reg;
        minute_next   = minute_reg;
        second_next   = second_reg;
        frac_next     = frac_reg;
        frac_cnt_next = frac_cnt_reg;
        off_sign_next = off_sign_reg;
        off_hour_next = off_hour_reg;
        off_min_next  = off_min_reg;
        off_idx_next  = off_idx_reg;
        ypair_next    = ypair_reg;
        yzero_next    = yzero_reg;
        yhi_mod4_next = yhi_mod4_reg;
        ylo_mod4_next = ylo_mod4_reg;
        ylo_zero_next = ylo_zero_reg;

        case (phase_reg)
            PH_BODY:
            begin
                if (pos_reg == POS_DASH1 || pos_reg == POS_DASH2)
                begin
                    err_next = err_reg || (ch_reg != CH_DASH);
                end
                else if (pos_reg == POS_T)
                begin
                    err_next = err_reg || (ch_reg != CH_T);
                end
                else if (pos_reg == POS_COLON1 || pos_reg == POS_COLON2)
                begin
                    err_next = err_reg || (ch_reg != CH_COLON);
                end
                else if (!is_dig)
                begin
                    err_next = 1'b1;
                end
                else if (pos_reg < POS_YEAR_END)
                begin
                    year_next = 14'(mul10_add(30'(year_reg), dig));
                    if (pos_reg == POS_Y0 || pos_reg == POS_Y2)
                    begin
                        ypair_next = {dig[0], 1'b0};
                        yzero_next = (dig == 4'd0);
                    end
                    else if (pos_reg == POS_Y1)
                    begin
                        yhi_mod4_next = ypair_reg + dig[1:0];
                    end
                    else if (pos_reg == POS_Y3)
                    begin
                        ylo_mod4_next = ypair_reg + dig[1:0];
                        ylo_zero_next = yzero_reg && (dig == 4'd0);
                    end
                end
                else if (pos_reg < POS_DASH2)
                begin
                    month_next = 7'(mul10_add(30'(month_reg), dig));
                end
                else if (pos_reg < POS_T)
                begin
                    day_next = 7'(mul10_add(30'(day_reg), dig));
                end
                else if (pos_reg < POS_COLON1)
                begin
                    hour_next = 7'(mul10_add(30'(hour_reg), dig));
                end
                else if (pos_reg < POS_COLON2)
                begin
                    minute_next = 7'(mul10_add(30'(minute_reg), dig));
                end
                else
                begin
                    second_next = 7'(mul10_add(30'(second_reg), dig));
                end
                if (pos_reg == POS_SEC_LAST)
                begin
                    phase_next = PH_AFTER_SEC;
                end
            end
            PH_AFTER_SEC, PH_FRAC:
            begin
                if (phase_reg == PH_FRAC && is_dig)
                begin
                    if (frac_cnt_reg < MAX_FRACTION_DIGITS)
                    begin
                        frac_next     = mul10_add(frac_reg, dig);
                        frac_cnt_next = frac_cnt_reg + 4'd1;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                else if (phase_reg == PH_FRAC && frac_cnt_reg == 4'd0)
                begin
                    err_next = 1'b1;
                end
                else if (ch_reg == CH_DOT && phase_reg == PH_AFTER_SEC)
                begin
                    phase_next    = PH_FRAC;
                    frac_cnt_next = 4'd0;
                end
                else if (ch_reg == CH_Z)
                begin
                    phase_next    = PH_AFTER_Z;
                    off_sign_next = OFS_PLUS;
                end
                else if (ch_reg == CH_PLUS || ch_reg == CH_DASH)
                begin
                    phase_next    = PH_OFFSET;
                    off_sign_next = (ch_reg == CH_DASH) ? OFS_MINUS : OFS_PLUS;
                    off_idx_next  = OFS_IDX_FIRST;
                end
                else
                begin
                    err_next = 1'b1;
                end
            end
            PH_OFFSET:
            begin
                if (off_idx_reg == OFS_IDX_COLON)
                begin
                    err_next = err_reg || (ch_reg != CH_COLON);
                end
                else if (off_idx_reg >= OFS_IDX_FIRST && off_idx_reg <= OFS_IDX_LAST)
                begin
                    if (!is_dig)
                    begin
                        err_next = 1'b1;
                    end
                    else if (off_idx_reg <= OFS_IDX_HOUR_END)
                    begin
                        off_hour_next = 7'(mul10_add(30'(off_hour_reg), dig));
                    end
                    else
                    begin
                        off_min_next = 7'(mul10_add(30'(off_min_reg), dig));
                    end
                end
                else
                begin
                    err_next = 1'b1;
                end
                if (off_idx_reg < OFS_IDX_DONE)
                begin
                    off_idx_next = off_idx_reg + 3'd1;
                end
            end
            default:
            begin
                err_next = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        time_seen = (phase_next != PH_BODY);
        leap      = (ylo_mod4_next == 2'd0) && (!ylo_zero_next || yhi_mod4_next == 2'd0);
        day_lim   = month_days(month_next[3:0], leap);
        off_total = (13'(off_hour_next) << 6) - (13'(off_hour_next) << 2) + 13'(off_min_next);

        ok = !err_next;
        if (phase_next == PH_BODY && pos_reg != POS_DATE_LAST)
        begin
            ok = 1'b0;
        end
        if (phase_next == PH_FRAC && frac_cnt_next == 4'd0)
        begin
            ok = 1'b0;
        end
        if (phase_next == PH_OFFSET && off_idx_next != OFS_IDX_DONE)
        begin
            ok = 1'b0;
        end
        if (phase_next > PH_OFFSET)
        begin
            ok = 1'b0;
        end
        if (year_next == 14'd0 || year_next > YEAR_MAX || month_next == 7'd0
            || month_next > MONTH_MAX || day_next == 7'd0 || day_next > 7'(day_lim))
        begin
            ok = 1'b0;
        end
        if (time_seen && (hour_next > HOUR_MAX || minute_next > MINUTE_MAX
            || second_next > SECOND_MAX))
        begin
            ok = 1'b0;
        end
        if (phase_next == PH_OFFSET && (off_hour_next > HOUR_MAX || off_min_next > MINUTE_MAX))
        begin
            ok = 1'b0;
        end

        res_data = '0;
        res_user = '0;
        if (ok)
        begin
            res_user[0]       = 1'b1;
            res_data[13:0]    = year_next;
            res_data[17:14]   = month_next[3:0];
            res_data[22:18]   = day_next[4:0];
            if (time_seen)
            begin
                res_user[1]     = 1'b1;
                res_user[3:2]   = off_sign_next;
                res_data[27:23] = hour_next[4:0];
                res_data[33:28] = minute_next[5:0];
                res_data[39:34] = second_next[5:0];
                res_data[69:40] = frac_next;
                res_data[73:70] = frac_cnt_next;
                if (phase_next == PH_OFFSET)
                begin
                    res_data[84:74] = off_total[10:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (proc_go)
            begin
                in_valid_reg <= 1'b0;
            end
            if (proc_go && last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            ch_reg   <= s_axis_tdata[7:0];
            last_reg <= s_axis_tlast;
        end
        if (proc_go && last_reg)
        begin
            out_data_reg <= res_data;
            out_user_reg <= res_user;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            phase_reg    <= PH_BODY;
            err_reg      <= 1'b0;
            year_reg     <= '0;
            month_reg    <= '0;
            day_reg      <= '0;
            hour_reg     <= '0;
            minute_reg   <= '0;
            second_reg   <= '0;
            frac_reg     <= '0;
            frac_cnt_reg <= '0;
            off_sign_reg <= OFS_NONE;
            off_hour_reg <= '0;
            off_min_reg  <= '0;
            off_idx_reg  <= '0;
            ypair_reg    <= '0;
            yzero_reg    <= 1'b0;
            yhi_mod4_reg <= '0;
            ylo_mod4_reg <= '0;
            ylo_zero_reg <= 1'b0;
        end
        else if (proc_go)
        begin
            if (last_reg)
            begin
                pos_reg      <= '0;
                phase_reg    <= PH_BODY;
                err_reg      <= 1'b0;
                year_reg     <= '0;
                month_reg    <= '0;
                day_reg      <= '0;
                hour_reg     <= '0;
                minute_reg   <= '0;
                second_reg   <= '0;
                frac_reg     <= '0;
                frac_cnt_reg <= '0;
                off_sign_reg <= OFS_NONE;
                off_hour_reg <= '0;
                off_min_reg  <= '0;
                off_idx_reg  <= '0;
                ypair_reg    <= '0;
                yzero_reg    <= 1'b0;
                yhi_mod4_reg <= '0;
                ylo_mod4_reg <= '0;
                ylo_zero_reg <= 1'b0;
            end
            else
            begin
                pos_reg      <= pos_next;
                phase_reg    <= phase_next;
                err_reg      <= err_next;
                year_reg     <= year_next;
                month_reg    <= month_next;
                day_reg      <= day_next;
                hour_reg     <= hour_next;
                minute_reg   <= minute_next;
                second_reg   <= second_next;
                frac_reg     <= frac_next;
                frac_cnt_reg <= frac_cnt_next;
                off_sign_reg <= off_sign_next;
                off_hour_reg <= off_hour_next;
                off_min_reg  <= off_min_next;
                off_idx_reg  <= off_idx_next;
                ypair_reg    <= ypair_next;
                yzero_reg    <= yzero_next;
                yhi_mod4_reg <= yhi_mod4_next;
                ylo_mod4_reg <= ylo_mod4_next;
                ylo_zero_reg <= ylo_zero_next;
            end
        end
    end

`ifndef SYNTH
    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_go && last_reg) |=> (pos_reg == 6'd0 && phase_reg == PH_BODY && !err_reg))
        else $error("parser state not cleared after final character");

    a_invalid_all_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0 && m_axis_tuser == '0))
        else $error("invalid result carries nonzero fields");

    a_no_time_no_extras: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[1])
            |-> (m_axis_tdata[87:23] == '0 && m_axis_tuser[3:2] == OFS_NONE))
        else $error("time-dependent fields set without a time part");

    a_frac_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        frac_cnt_reg <= MAX_FRACTION_DIGITS)
        else $error("fraction digit count beyond its limit");
`endif

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the date-time text parser: directed strings, then random strings.
module testbench;
    import idtp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_CHARS = 160;

    typedef struct packed {
        logic        valid;
        logic        time_part;
        logic [1:0]  kind;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [29:0] frac;
        logic [3:0]  digits;
        logic [10:0] ofs_min;
        logic [2:0]  pad;
    } datetime_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count = 0;
    int mismatches = 0;
    int chars_sent = 0;
    int strings_sent = 0;
    int results_seen = 0;
    int valid_seen = 0;

    datetime_t  expected_dates[$];
    datetime_t  want;
    datetime_t  got;
    logic [7:0] text_buf[$];
    string      text_symbols = "0123456789-+:.TZ";

    logic [5:0]  pos_cnt;
    phase_t      phase;
    logic        err_flag;
    logic [13:0] yr;
    logic [6:0]  mon;
    logic [6:0]  dy;
    logic [6:0]  hr;
    logic [6:0]  mi;
    logic [6:0]  se;
    logic [29:0] frac_val;
    logic [3:0]  frac_cnt;
    logic [1:0]  ofs_kind;
    logic [6:0]  ofs_hr;
    logic [6:0]  ofs_mi;
    logic [2:0]  ofs_idx;

    iso_datetime_text_parser dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_dates.size());
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic is_digit_ch(input logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic logic date_valid(input logic [13:0] y, input logic [6:0] m,
                                        input logic [6:0] d);
        logic leap;
        int   lim;
        leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        case (m)
            1, 3, 5, 7, 8, 10, 12: lim = 31;
            4, 6, 9, 11:           lim = 30;
            2:                     lim = leap ? 29 : 28;
            default:               lim = 0;
        endcase
        return y != 0 && y <= YEAR_MAX && d != 0 && d <= lim;
    endfunction

    function automatic int mostly_in(input int lo, input int hi);
        if ($urandom_range(9) != 0)
            return $urandom_range(hi, lo);
        return $urandom_range(99);
    endfunction

    task automatic clear_parser();
        pos_cnt  = '0;
        phase    = PH_BODY;
        err_flag = 1'b0;
        yr       = '0;
        mon      = '0;
        dy       = '0;
        hr       = '0;
        mi       = '0;
        se       = '0;
        frac_val = '0;
        frac_cnt = '0;
        ofs_kind = OFS_NONE;
        ofs_hr   = '0;
        ofs_mi   = '0;
        ofs_idx  = '0;
    endtask

    // Character following the seconds or the fraction digits.
    task automatic enter_suffix(input logic [7:0] c, input logic allow_dot);
        if (c == CH_DOT && allow_dot)
        begin
            phase    = PH_FRAC;
            frac_cnt = '0;
        end
        else if (c == CH_Z)
        begin
            phase    = PH_AFTER_Z;
            ofs_kind = OFS_PLUS;
        end
        else if (c == CH_PLUS || c == CH_DASH)
        begin
            phase    = PH_OFFSET;
            ofs_kind = (c == CH_DASH) ? OFS_MINUS : OFS_PLUS;
            ofs_idx  = OFS_IDX_FIRST;
        end
        else
            err_flag = 1'b1;
    endtask

    task automatic advance_parser(input logic [7:0] c, input logic fin);
        datetime_t  r;
        logic [5:0] p;
        logic [3:0] dv;
        logic       ok;
        logic       timed;
        p  = pos_cnt;
        dv = c[3:0];
        case (phase)
            PH_BODY:
            begin
                if (p == POS_DASH1 || p == POS_DASH2)
                begin
                    if (c != CH_DASH) err_flag = 1'b1;
                end
                else if (p == POS_T)
                begin
                    if (c != CH_T) err_flag = 1'b1;
                end
                else if (p == POS_COLON1 || p == POS_COLON2)
                begin
                    if (c != CH_COLON) err_flag = 1'b1;
                end
                else if (!is_digit_ch(c))
                    err_flag = 1'b1;
                else if (p < POS_DASH1)
                    yr = yr * 14'd10 + dv;
                else if (p < POS_DASH2)
                    mon = mon * 7'd10 + dv;
                else if (p < POS_T)
                    dy = dy * 7'd10 + dv;
                else if (p < POS_COLON1)
                    hr = hr * 7'd10 + dv;
                else if (p < POS_COLON2)
                    mi = mi * 7'd10 + dv;
                else
                    se = se * 7'd10 + dv;
                if (p == POS_SEC_LAST) phase = PH_AFTER_SEC;
            end
            PH_AFTER_SEC: enter_suffix(c, 1'b1);
            PH_FRAC:
            begin
                if (is_digit_ch(c))
                begin
                    if (frac_cnt < MAX_FRACTION_DIGITS)
                    begin
                        frac_val = frac_val * 30'd10 + dv;
                        frac_cnt++;
                    end
                    else
                        err_flag = 1'b1;
                end
                else if (frac_cnt == 0)
                    err_flag = 1'b1;
                else
                    enter_suffix(c, 1'b0);
            end
            PH_OFFSET:
            begin
                if (ofs_idx == OFS_IDX_COLON)
                begin
                    if (c != CH_COLON) err_flag = 1'b1;
                end
                else if (ofs_idx >= OFS_IDX_FIRST && ofs_idx <= OFS_IDX_LAST)
                begin
                    if (!is_digit_ch(c))
                        err_flag = 1'b1;
                    else if (ofs_idx <= OFS_IDX_HOUR_END)
                        ofs_hr = ofs_hr * 7'd10 + dv;
                    else
                        ofs_mi = ofs_mi * 7'd10 + dv;
                end
                else
                    err_flag = 1'b1;
                if (ofs_idx < OFS_IDX_DONE) ofs_idx++;
            end
            default: err_flag = 1'b1;
        endcase
        if (pos_cnt < POS_MAX) pos_cnt++;

        if (fin)
        begin
            ok    = !err_flag;
            timed = (phase != PH_BODY);
            if (phase == PH_BODY && p != POS_DATE_LAST) ok = 1'b0;
            if (phase == PH_FRAC && frac_cnt == 0) ok = 1'b0;
            if (phase == PH_OFFSET && ofs_idx != OFS_IDX_DONE) ok = 1'b0;
            if (!date_valid(yr, mon, dy)) ok = 1'b0;
            if (timed && (hr > HOUR_MAX || mi > MINUTE_MAX || se > SECOND_MAX)) ok = 1'b0;
            if (phase == PH_OFFSET && (ofs_hr > HOUR_MAX || ofs_mi > MINUTE_MAX)) ok = 1'b0;
            r = '0;
            if (ok)
            begin
                r.valid = 1'b1;
                r.year  = yr;
                r.month = mon[3:0];
                r.day   = dy[4:0];
                if (timed)
                begin
                    r.time_part = 1'b1;
                    r.hour      = hr[4:0];
                    r.minute    = mi[5:0];
                    r.second    = se[5:0];
                    r.frac      = frac_val;
                    r.digits    = frac_cnt;
                    r.kind      = ofs_kind;
                    if (phase == PH_OFFSET) r.ofs_min = ofs_hr * 11'd60 + ofs_mi;
                end
            end
            expected_dates.push_back(r);
            clear_parser();
        end
    endtask

    task automatic check_field(input string name, input int expv, input int actv);
        if (expv != actv)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                advance_parser(s_axis_tdata, s_axis_tlast);
                chars_sent++;
                if (s_axis_tlast) strings_sent++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                got.valid     = m_axis_tuser[0];
                got.time_part = m_axis_tuser[1];
                got.kind      = m_axis_tuser[3:2];
                got.year      = m_axis_tdata[13:0];
                got.month     = m_axis_tdata[17:14];
                got.day       = m_axis_tdata[22:18];
                got.hour      = m_axis_tdata[27:23];
                got.minute    = m_axis_tdata[33:28];
                got.second    = m_axis_tdata[39:34];
                got.frac      = m_axis_tdata[69:40];
                got.digits    = m_axis_tdata[73:70];
                got.ofs_min   = m_axis_tdata[84:74];
                got.pad       = m_axis_tdata[87:85];
                if (got.valid) valid_seen++;
                if (expected_dates.size() == 0)
                begin
                    $display("%0t: result beat with no string pending, expected none, actual %h/%h",
                             $time, m_axis_tuser, m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_dates.pop_front();
                    check_field("valid_res", want.valid, got.valid);
                    check_field("time_present", want.time_part, got.time_part);
                    check_field("offset_kind", want.kind, got.kind);
                    check_field("year", want.year, got.year);
                    check_field("month", want.month, got.month);
                    check_field("day", want.day, got.day);
                    check_field("hour", want.hour, got.hour);
                    check_field("minute", want.minute, got.minute);
                    check_field("second", want.second, got.second);
                    check_field("fraction_value", want.frac, got.frac);
                    check_field("fraction_digits", want.digits, got.digits);
                    check_field("offset_minutes", want.ofs_min, got.ofs_min);
                    check_field("tdata padding", want.pad, got.pad);
                end
            end
        end
    end

    task automatic send_char(input logic [7:0] c, input logic fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= fin;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    task automatic send_buf();
        for (int i = 0; i < text_buf.size(); i++)
            send_char(text_buf[i], i == text_buf.size() - 1);
    endtask

    task automatic send_text(input string s);
        text_buf = {};
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
        send_buf();
    endtask

    task automatic put_num(input int v, input int n);
        int scale;
        scale = 1;
        repeat (n - 1) scale *= 10;
        for (int i = 0; i < n; i++)
        begin
            text_buf.push_back(CH_0 + 8'((v / scale) % 10));
            scale /= 10;
        end
    endtask

    task automatic put_junk();
        if ($urandom_range(1))
            text_buf.push_back(8'($urandom_range(255)));
        else
            text_buf.push_back(text_symbols[$urandom_range(text_symbols.len() - 1)]);
    endtask

    task automatic make_random_text();
        int n;
        int pick;
        int yr_v;
        text_buf = {};
        if ($urandom_range(99) < 12)
        begin
            repeat ($urandom_range(70, 1)) put_junk();
            return;
        end
        case ($urandom_range(3))
            0:       yr_v = $urandom_range(9999);
            1:       yr_v = 4 * $urandom_range(2499);
            2:       yr_v = 100 * $urandom_range(99);
            default: yr_v = $urandom_range(9999, 1);
        endcase
        put_num(yr_v, 4);
        text_buf.push_back(CH_DASH);
        put_num(mostly_in(1, 12), 2);
        text_buf.push_back(CH_DASH);
        put_num(mostly_in(1, 31), 2);
        if ($urandom_range(3) != 0)
        begin
            text_buf.push_back(CH_T);
            put_num(mostly_in(0, 23), 2);
            text_buf.push_back(CH_COLON);
            put_num(mostly_in(0, 59), 2);
            text_buf.push_back(CH_COLON);
            put_num(($urandom_range(9) == 0) ? 60 : mostly_in(0, 59), 2);
            pick = $urandom_range(99);
            if (pick < 48)
            begin
                if (pick < 40)
                    n = $urandom_range(9, 1);
                else if (pick < 45)
                    n = $urandom_range(11, 10);
                else
                    n = 0;
                text_buf.push_back(CH_DOT);
                repeat (n) text_buf.push_back(CH_0 + 8'($urandom_range(9)));
            end
            pick = $urandom_range(3);
            if (pick == 1)
                text_buf.push_back(CH_Z);
            else if (pick > 1)
            begin
                text_buf.push_back((pick == 2) ? CH_PLUS : CH_DASH);
                if ($urandom_range(7) == 0)
                begin
                    put_num(0, 2);
                    text_buf.push_back(CH_COLON);
                    put_num(0, 2);
                end
                else
                begin
                    put_num(mostly_in(0, 23), 2);
                    text_buf.push_back(CH_COLON);
                    put_num(mostly_in(0, 59), 2);
                end
            end
        end
        if ($urandom_range(99) < 15)
        begin
            case ($urandom_range(2))
                0:
                begin
                    n = $urandom_range(text_buf.size(), 1);
                    while (text_buf.size() > n) void'(text_buf.pop_back());
                end
                1:       text_buf[$urandom_range(text_buf.size() - 1)] = 8'($urandom_range(255));
                default: repeat ($urandom_range(45, 1)) put_junk();
            endcase
        end
    endtask

    task automatic test_calendar();
        send_text("2000-02-29");
        send_text("1900-02-29");
        send_text("2024-02-29");
        send_text("2023-02-29");
        send_text("9999-12-31");
        send_text("0000-01-01");
        send_text("0001-01-01");
        send_text("2021-13-01");
        send_text("2021-04-31");
    endtask

    task automatic test_time_and_offsets();
        send_text("2021-06-30T23:59:60");
        send_text("1999-12-31T00:00:00.123456789Z");
        send_text("2021-06-30T12:34:56.000100+14:30");
        send_text("2021-06-30T12:34:56-00:00");
        send_text("2021-06-30T23:59:59+23:59");
        send_text("2021-06-30T24:00:00");
        send_text("2021-06-30T12:00:00-24:00");
    endtask

    task automatic test_malformed();
        send_text("2021-06-30T12:34:56.1234567890");
        send_text("2021-06-30T12:34:56.");
        send_text("2021-06-30T12:34:56+05:");
        send_text("2021-06-30T12:3");
        send_text("2021/06/30");
        send_text("2021-06-30T12:34:56Z1");
        send_text("2021-06-30T12:34:56.123456789+01:0000000000000000000000000000000000");
        send_text("7");
    endtask

    task automatic test_random_strings(input int send_pct, input int recv_pct);
        int budget;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        budget = RANDOM_CHARS;
        while (budget > 0)
        begin
            make_random_text();
            budget -= text_buf.size();
            send_buf();
        end
    endtask

    initial
    begin
        clear_parser();
        send_idle_pct = 32;
        recv_idle_pct = 85;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_calendar();
        test_time_and_offsets();
        test_malformed();
        test_random_strings(32, 85);
        test_random_strings(85, 32);
        test_random_strings(0, 0);

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_dates.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d characters in %0d strings, checked %0d result beats (%0d valid).",
                 chars_sent, strings_sent, results_seen, valid_seen);
        $display("Covered sender-heavy, receiver-heavy and gap-free traffic; %0d mismatches.",
                 mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
